// ----- rtl/pacf_pkg.sv -----
`timescale 1ns / 1ps

package pacf_pkg;

  // Datapath and instruction field widths.
  localparam int unsigned DataW     = 32;
  localparam int unsigned RegFieldW = 8;
  localparam int unsigned RegIdxW   = 5;

  // Instruction word layout: opcode, dest, src_a, src_b from the top byte down.
  localparam int unsigned OpcodeLsb = 24;
  localparam int unsigned DestLsb   = 16;
  localparam int unsigned SrcALsb   = 8;
  localparam int unsigned SrcBLsb   = 0;

  // Default size of the register file.
  localparam int unsigned NumRegsDefault = 32;

  // Command codes of an input item.
  typedef enum logic {
    CMD_STEP    = 1'b0,
    CMD_PRELOAD = 1'b1
  } cmd_e;

  // ALU opcodes; every other opcode yields zero.
  typedef enum logic [RegFieldW-1:0] {
    OP_ADD = 8'd0,
    OP_SUB = 8'd1,
    OP_AND = 8'd2,
    OP_OR  = 8'd3
  } alu_op_e;

  // Input item.
  typedef struct packed {
    logic                 cmd;
    logic [DataW-1:0]     instr;
    logic [RegIdxW-1:0]   reg_index;
    logic [DataW-1:0]     reg_value;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [RegFieldW-1:0] wb_reg;
    logic [DataW-1:0]     wb_value;
  } out_item_t;

  // Destination and result held in a late pipeline latch.
  typedef struct packed {
    logic [RegFieldW-1:0] dest;
    logic [DataW-1:0]     result;
  } fwd_t;

  // Register file write request.
  typedef struct packed {
    logic                 en;
    logic [RegFieldW-1:0] idx;
    logic [DataW-1:0]     data;
  } rf_wr_t;

endpackage

// ----- rtl/pacf_regfile.sv -----
`timescale 1ns / 1ps

module pacf_regfile import pacf_pkg::*; #(
  parameter int unsigned NumRegs = NumRegsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rf_wr_t               wr_i,
  input  logic                 rd_en_i,
  input  logic [RegFieldW-1:0] rd_idx_a_i,
  input  logic [RegFieldW-1:0] rd_idx_b_i,
  output logic [DataW-1:0]     rd_data_a_o,
  output logic [DataW-1:0]     rd_data_b_o
);

  localparam int unsigned IdxW = $clog2(NumRegs);

  // Register zero and indices past the end are not backed by storage.
  function automatic logic idx_ok(input logic [RegFieldW-1:0] idx);
    logic ok;
    ok = ({1'b0, idx} < (RegFieldW + 1)'(NumRegs)) && (idx != '0);
    return ok;
  endfunction

  logic [DataW-1:0]   mem_q [NumRegs];
  logic [NumRegs-1:0] vld_q;
  logic [DataW-1:0]   rd_a_q, rd_b_q;
  logic               wr_ok;
  logic [IdxW-1:0]    wr_addr, rd_a_addr, rd_b_addr;

  assign wr_ok     = wr_i.en && idx_ok(wr_i.idx);
  assign wr_addr   = wr_i.idx[IdxW-1:0];
  assign rd_a_addr = rd_idx_a_i[IdxW-1:0];
  assign rd_b_addr = rd_idx_b_i[IdxW-1:0];

  // Storage array; written entries are marked valid, the rest read as zero.
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem_q[wr_addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_ok) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  // Registered reads; a write in the same cycle is passed straight through.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_a_q <= '0;
      rd_b_q <= '0;
    end else if (rd_en_i) begin
      if (wr_ok && (wr_i.idx == rd_idx_a_i)) begin
        rd_a_q <= wr_i.data;
      end else if (idx_ok(rd_idx_a_i) && vld_q[rd_a_addr]) begin
        rd_a_q <= mem_q[rd_a_addr];
      end else begin
        rd_a_q <= '0;
      end
      if (wr_ok && (wr_i.idx == rd_idx_b_i)) begin
        rd_b_q <= wr_i.data;
      end else if (idx_ok(rd_idx_b_i) && vld_q[rd_b_addr]) begin
        rd_b_q <= mem_q[rd_b_addr];
      end else begin
        rd_b_q <= '0;
      end
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

// ----- rtl/pacf_exec.sv -----
`timescale 1ns / 1ps

module pacf_exec import pacf_pkg::*; (
  input  logic [RegFieldW-1:0] op_i,
  input  logic [RegFieldW-1:0] src_a_i,
  input  logic [RegFieldW-1:0] src_b_i,
  input  logic [DataW-1:0]     opnd_a_i,
  input  logic [DataW-1:0]     opnd_b_i,
  input  fwd_t                 mem_fwd_i,
  input  fwd_t                 wb_fwd_i,
  output logic [DataW-1:0]     result_o
);

  // The younger latch wins; a zero dest never forwards.
  function automatic logic [DataW-1:0] fwd_pick(input logic [RegFieldW-1:0] src,
                                                input logic [DataW-1:0] latched,
                                                input fwd_t mem_f,
                                                input fwd_t wb_f);
    logic [DataW-1:0] val;
    if ((mem_f.dest != '0) && (mem_f.dest == src)) begin
      val = mem_f.result;
    end else if ((wb_f.dest != '0) && (wb_f.dest == src)) begin
      val = wb_f.result;
    end else begin
      val = latched;
    end
    return val;
  endfunction

  logic [DataW-1:0] a, b;

  assign a = fwd_pick(src_a_i, opnd_a_i, mem_fwd_i, wb_fwd_i);
  assign b = fwd_pick(src_b_i, opnd_b_i, mem_fwd_i, wb_fwd_i);

  // ALU.
  always_comb begin
    case (op_i)
      OP_ADD:  result_o = a + b;
      OP_SUB:  result_o = a - b;
      OP_AND:  result_o = a & b;
      OP_OR:   result_o = a | b;
      default: result_o = '0;
    endcase
  end

endmodule

// ----- rtl/pipelined_alu_core_forwarding.sv -----
`timescale 1ns / 1ps

// Integer pipeline with decode, execute, memory and writeback latches.
// Input channel: each item either preloads one register (cmd set) or clocks
// the pipeline once, with instr entering the decode latch. Results appear on
// the output channel as (wb_reg, wb_value) when an instruction with a nonzero
// dest retires; preloads and retiring zero-dest words give no item.
// An instruction retires on the fourth step item after the one carrying it;
// its result item enters the output register, or the skid register on a
// stall. Throughput is one item per cycle while the skid register is empty;
// the ALU and forwarding muxes sit between the execute and memory latches.
// Reset clears the register file (through per-entry valid bits), all latches
// and the output stage; no item is pending afterwards.
// A stalled output keeps its item; a second result waits in a skid register,
// and only while that register is full does the input channel stall.
module pipelined_alu_core_forwarding import pacf_pkg::*; #(
  parameter int unsigned NumRegs = NumRegsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic                 accept, step, preload, produce, out_pop;
  logic [DataW-1:0]     dec_word_q;
  logic [RegFieldW-1:0] ex_op_q, ex_dest_q, ex_src_a_q, ex_src_b_q;
  logic [DataW-1:0]     ex_opnd_a, ex_opnd_b, ex_result;
  fwd_t                 mem_q, wb_q;
  rf_wr_t               rf_wr;
  out_item_t            out_q, skid_q, new_item;
  logic                 out_v_q, skid_v_q;

  assign accept  = in_valid_i && !skid_v_q;
  assign step    = accept && (in_item_i.cmd == CMD_STEP);
  assign preload = accept && (in_item_i.cmd == CMD_PRELOAD);
  assign produce = step && (wb_q.dest != '0);
  assign out_pop = out_v_q && !out_stall_i;

  // Register file write: a preload, or the retiring instruction on a step.
  always_comb begin
    if (preload) begin
      rf_wr.en   = 1'b1;
      rf_wr.idx  = RegFieldW'(in_item_i.reg_index);
      rf_wr.data = in_item_i.reg_value;
    end else begin
      rf_wr.en   = step && (wb_q.dest != '0);
      rf_wr.idx  = wb_q.dest;
      rf_wr.data = wb_q.result;
    end
  end

  // Decode reads land directly in the execute latch operands.
  pacf_regfile #(
    .NumRegs(NumRegs)
  ) u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (rf_wr),
    .rd_en_i    (step),
    .rd_idx_a_i (dec_word_q[SrcALsb +: RegFieldW]),
    .rd_idx_b_i (dec_word_q[SrcBLsb +: RegFieldW]),
    .rd_data_a_o(ex_opnd_a),
    .rd_data_b_o(ex_opnd_b)
  );

  pacf_exec u_exec (
    .op_i     (ex_op_q),
    .src_a_i  (ex_src_a_q),
    .src_b_i  (ex_src_b_q),
    .opnd_a_i (ex_opnd_a),
    .opnd_b_i (ex_opnd_b),
    .mem_fwd_i(mem_q),
    .wb_fwd_i (wb_q),
    .result_o (ex_result)
  );

  // Pipeline latches advance together on each step item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_word_q <= '0;
      ex_op_q    <= '0;
      ex_dest_q  <= '0;
      ex_src_a_q <= '0;
      ex_src_b_q <= '0;
      mem_q      <= '0;
      wb_q       <= '0;
    end else if (step) begin
      wb_q        <= mem_q;
      mem_q       <= '{dest: ex_dest_q, result: ex_result};
      ex_op_q     <= dec_word_q[OpcodeLsb +: RegFieldW];
      ex_dest_q   <= dec_word_q[DestLsb +: RegFieldW];
      ex_src_a_q  <= dec_word_q[SrcALsb +: RegFieldW];
      ex_src_b_q  <= dec_word_q[SrcBLsb +: RegFieldW];
      dec_word_q  <= in_item_i.instr;
    end
  end

  assign new_item.wb_reg   = wb_q.dest;
  assign new_item.wb_value = wb_q.result;

  // Output register with a skid register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
      out_q    <= '0;
      skid_q   <= '0;
    end else if (skid_v_q) begin
      if (out_pop) begin
        out_q    <= skid_q;
        skid_v_q <= 1'b0;
      end
    end else if (!out_v_q || out_pop) begin
      out_v_q <= produce;
      if (produce) begin
        out_q <= new_item;
      end
    end else if (produce) begin
      skid_q   <= new_item;
      skid_v_q <= 1'b1;
    end
  end

  assign in_stall_o  = skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import pacf_pkg::*;

  // Cycles without any accepted item before the run is declared hung.
  localparam int unsigned StallLimit = 400;
  localparam int unsigned RandomItems = 650;
  localparam int unsigned RfIdxW = $clog2(NumRegsDefault);

  // Predicts the writeback items of the pipeline and checks the ones that come out.
  class WritebackScoreboard;
    logic [DataW-1:0]     regs [NumRegsDefault];
    logic [DataW-1:0]     dec_word;
    logic [RegFieldW-1:0] ex_op, ex_dest, ex_src_a, ex_src_b;
    logic [DataW-1:0]     ex_opnd_a, ex_opnd_b;
    logic [RegFieldW-1:0] mem_dst, wb_dest;
    logic [DataW-1:0]     mem_res, wb_res;
    out_item_t            wb_expected [$];
    int unsigned          mismatches, checked, preloads, steps;

    function new();
      foreach (regs[i]) regs[i] = '0;
      dec_word = '0;
      ex_op = '0;
      ex_dest = '0;
      ex_src_a = '0;
      ex_src_b = '0;
      ex_opnd_a = '0;
      ex_opnd_b = '0;
      mem_dst = '0;
      mem_res = '0;
      wb_dest = '0;
      wb_res = '0;
      mismatches = 0;
      checked = 0;
      preloads = 0;
      steps = 0;
    endfunction

    // Register 0 and indices past the file read as zero.
    function logic [DataW-1:0] rf_get(logic [RegFieldW-1:0] idx);
      if (idx != 0 && idx < NumRegsDefault) return regs[idx[RfIdxW-1:0]];
      return '0;
    endfunction

    function void rf_put(logic [RegFieldW-1:0] idx, logic [DataW-1:0] v);
      if (idx != 0 && idx < NumRegsDefault) regs[idx[RfIdxW-1:0]] = v;
    endfunction

    function logic [DataW-1:0] alu_calc(logic [RegFieldW-1:0] op,
                                        logic [DataW-1:0] a, logic [DataW-1:0] b);
      case (op)
        OP_ADD:  return a + b;
        OP_SUB:  return a - b;
        OP_AND:  return a & b;
        OP_OR:   return a | b;
        default: return '0;
      endcase
    endfunction

    // The execute/memory latch wins over the memory/writeback latch.
    function logic [DataW-1:0] bypass(logic [RegFieldW-1:0] src, logic [DataW-1:0] latched);
      if (mem_dst != 0 && mem_dst == src) return mem_res;
      if (wb_dest != 0 && wb_dest == src) return wb_res;
      return latched;
    endfunction

    function void note_input(in_item_t it);
      out_item_t            res;
      logic [RegFieldW-1:0] nxt_wb_dest, nxt_mem_dest;
      logic [DataW-1:0]     nxt_wb_res, nxt_mem_res, w;
      if (it.cmd == CMD_PRELOAD) begin
        rf_put(RegFieldW'(it.reg_index), it.reg_value);
        preloads++;
        return;
      end
      steps++;
      // Writeback happens first so decode sees it in the same step.
      if (wb_dest != 0) begin
        rf_put(wb_dest, wb_res);
        res.wb_reg = wb_dest;
        res.wb_value = wb_res;
        wb_expected.push_back(res);
      end
      nxt_wb_dest = mem_dst;
      nxt_wb_res = mem_res;
      nxt_mem_dest = ex_dest;
      nxt_mem_res = alu_calc(ex_op, bypass(ex_src_a, ex_opnd_a), bypass(ex_src_b, ex_opnd_b));
      w = dec_word;
      // All latches advance together.
      wb_dest = nxt_wb_dest;
      wb_res = nxt_wb_res;
      mem_dst = nxt_mem_dest;
      mem_res = nxt_mem_res;
      ex_op = w[OpcodeLsb +: RegFieldW];
      ex_dest = w[DestLsb +: RegFieldW];
      ex_src_a = w[SrcALsb +: RegFieldW];
      ex_src_b = w[SrcBLsb +: RegFieldW];
      ex_opnd_a = rf_get(ex_src_a);
      ex_opnd_b = rf_get(ex_src_b);
      dec_word = it.instr;
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      bit        bad;
      string     why;
      if (wb_expected.size() == 0) begin
        exp = '0;
        bad = 1'b1;
        why = "no writeback expected";
      end else begin
        exp = wb_expected.pop_front();
        checked++;
        bad = (got.wb_reg !== exp.wb_reg) || (got.wb_value !== exp.wb_value);
        why = "field mismatch";
      end
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch (%s): expected reg %0d value %h, got reg %0d value %h",
                   why, exp.wb_reg, exp.wb_value, got.wb_reg, got.wb_value);
      end
    endfunction

    function int pending();
      return wb_expected.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  WritebackScoreboard sb;
  bit                 send_burst;
  bit                 recv_burst;
  int unsigned        idle_cycles;
  logic [RegFieldW-1:0] recent_dests [$];

  pipelined_alu_core_forwarding DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    send_burst = 1'b0;
    recv_burst = 1'b0;
    idle_cycles = 0;
    sb = new();
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Idle cycles per item; burst stretches run with no idling at all.
  function automatic int unsigned draw_gap(bit burst);
    if (burst) return 0;
    return $urandom_range(0, 14);
  endfunction

  // Result monitor and hang watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_item);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("Timeout: no item accepted for %0d cycles", StallLimit);
          $display("FAIL pipelined_alu_core_forwarding");
          $finish;
        end
      end
    end
  end

  // Result side: stall for a random number of cycles before each item.
  initial begin : rx_side
    int unsigned n;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      n = draw_gap(recv_burst);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send_item(in_item_t it);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    @(negedge clk);
  endtask

  task automatic preload(logic [RegIdxW-1:0] idx, logic [DataW-1:0] val);
    in_item_t it;
    it.cmd = CMD_PRELOAD;
    it.instr = $urandom();
    it.reg_index = idx;
    it.reg_value = val;
    send_item(it);
  endtask

  task automatic step(logic [DataW-1:0] word);
    in_item_t it;
    it.cmd = CMD_STEP;
    it.instr = word;
    it.reg_index = $urandom();
    it.reg_value = $urandom();
    send_item(it);
  endtask

  // Hold the sender off until every predicted writeback has been seen.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() > 0) @(negedge clk);
  endtask

  function automatic logic [DataW-1:0] mk(logic [RegFieldW-1:0] op, logic [RegFieldW-1:0] dest,
                                         logic [RegFieldW-1:0] sa, logic [RegFieldW-1:0] sb_idx);
    return {op, dest, sa, sb_idx};
  endfunction

  // Sources favor recent destinations so that hazards hit the bypass paths.
  function automatic logic [RegFieldW-1:0] pick_source();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5 && recent_dests.size() > 0)
      return recent_dests[$urandom_range(0, recent_dests.size() - 1)];
    if (r == 5) return RegFieldW'($urandom());
    return RegFieldW'($urandom_range(0, NumRegsDefault - 1));
  endfunction

  function automatic logic [DataW-1:0] random_instr();
    logic [RegFieldW-1:0] op, dest;
    int unsigned          r;
    if ($urandom_range(0, 99) < 8) return $urandom();
    op = ($urandom_range(0, 9) == 0) ? RegFieldW'($urandom()) : RegFieldW'($urandom_range(0, 3));
    r = $urandom_range(0, 19);
    if (r == 0) dest = '0;
    else if (r == 1) dest = RegFieldW'($urandom());
    else dest = RegFieldW'($urandom_range(1, NumRegsDefault - 1));
    return mk(op, dest, pick_source(), pick_source());
  endfunction

  function automatic logic [DataW-1:0] random_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  initial begin : stimulus
    logic [DataW-1:0] w;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part: operand extremes, each opcode, bypass distances and odd indices.
    preload(1, 32'hFFFF_FFFF);
    preload(2, 32'h0000_0000);
    preload(3, 32'h8000_0000);
    preload(4, 32'h0000_0001);
    preload(31, 32'hA5A5_A5A5);
    preload(0, 32'hDEAD_BEEF);
    step(mk(OP_ADD, 5, 1, 4));
    step(mk(OP_ADD, 8, 5, 3));
    step(mk(OP_SUB, 9, 5, 8));
    step(mk(OP_AND, 10, 1, 5));
    step(mk(OP_OR, 11, 3, 4));
    step(mk(8'hFF, 12, 1, 1));
    step(mk(OP_ADD, 0, 1, 31));
    step(mk(OP_SUB, 40, 1, 31));
    step(mk(OP_ADD, 13, 40, 40));
    step(mk(OP_ADD, 255, 31, 200));
    step('0);
    step(mk(OP_OR, 14, 255, 0));
    preload(5, 32'h1234_5678);
    step(32'hFFFF_FFFF);
    step(mk(OP_SUB, 15, 2, 1));
    repeat (4) step('0);
    drain();

    // Random part: mostly hazard-rich instruction streams, some preloads and raw words.
    for (int unsigned i = 0; i < RandomItems; i++) begin
      if (i % 100 == 99) drain();
      if ($urandom_range(0, 99) < 15) begin
        preload(RegIdxW'($urandom()), random_value());
      end else begin
        w = random_instr();
        step(w);
        recent_dests.push_back(w[DestLsb +: RegFieldW]);
        if (recent_dests.size() > 3) void'(recent_dests.pop_front());
      end
    end
    repeat (4) step('0);
    drain();
    repeat (8) @(posedge clk);

    $display("Covered %0d items: %0d preloads and %0d pipeline steps, %0d writebacks checked.",
             sb.preloads + sb.steps, sb.preloads, sb.steps, sb.checked);
    $display("Stream mixed all opcodes, bypass hazards and out-of-range indices under stalls.");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS pipelined_alu_core_forwarding");
    end else begin
      $display("%0d mismatches, %0d writebacks missing", sb.mismatches, sb.pending());
      $display("FAIL pipelined_alu_core_forwarding");
    end
    $finish;
  end

endmodule
